// ===== design/sky_texel_address_generator_macros.svh =====
// assertion helpers used by the design file
`ifndef SKY_TEXEL_ADDRESS_GENERATOR_MACROS_SVH
`define SKY_TEXEL_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define STAG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sky texel check failed");

// next-cycle implication, checked through reset as well
`define STAG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sky texel check failed");

`endif

// ===== design/stag_pkg.sv =====
package stag_pkg;

  localparam int FINE_ANGLES = 3600;
  localparam int FRAC_BITS   = 16;
  localparam int ANG_W       = $clog2(FINE_ANGLES);

  // bias that lifts the signed angle sum above zero, and how many turns remain
  localparam int ANG_BIAS  = FINE_ANGLES * ((4096 + FINE_ANGLES - 1) / FINE_ANGLES);
  localparam int ANG_MULTS = (8190 + ANG_BIAS) / FINE_ANGLES;

  // exact floor division of a 22-bit product by FINE_ANGLES via reciprocal
  localparam int          COL_PROD_W = 22;
  localparam int          COL_SHIFT  = COL_PROD_W + 12;
  localparam int          COL_RECIP_W = 23;
  localparam longint      COL_RECIP_L =
    ((64'sd1 <<< COL_SHIFT) + FINE_ANGLES - 1) / FINE_ANGLES;
  localparam logic [COL_RECIP_W-1:0] COL_RECIP = COL_RECIP_W'(COL_RECIP_L);

  // remainder pipeline: 24 numerator bits, three per stage
  localparam int DIV_STAGES = 8;

  localparam logic [2:0] REG_VIEW_ANGLE    = 3'd0;
  localparam logic [2:0] REG_ROW_SHIFT     = 3'd1;
  localparam logic [2:0] REG_ROW_STEP      = 3'd2;
  localparam logic [2:0] REG_TEX_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_TEX_WIDTH     = 3'd4;
  localparam logic [2:0] REG_HEIGHT_FACTOR = 3'd5;
  localparam logic [2:0] REG_HORIZON_ROW   = 3'd6;
  localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd7;

  typedef logic [9:0] rem_t;

endpackage

// ===== design/sky_texel_address_generator.sv =====
// sky texel address generator
// one request per pixel: start with column_angle, wall_height, screen_row.
// busy is tied low, so a request is taken on every cycle that start is high.
// each request gives one result on draw_sky, texel_column
// and texel_row, marked by done for a single cycle. the receiver cannot
// stall; results simply flow out in request order.
// throughput is one pixel per clock. latency is set by the texel row
// remainder, which resolves three quotient bits per stage over eight stages
// after the input multiply stage and one alignment stage.
// the apb port holds eight registers at byte addresses 0 to 28; pready is
// always high. the user changes registers only while no request is in flight; the block does not enforce it.
// reset (synchronous, active high) loads the register defaults and
// clears every pipeline valid bit, so no done pulse follows reset.
`include "sky_texel_address_generator_macros.svh"

module sky_texel_address_generator
  import stag_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [12:0] column_angle,
  input  logic [15:0]        wall_height,
  input  logic [9:0]         screen_row,
  output logic               done,
  output logic               draw_sky,
  output logic [9:0]         texel_column,
  output logic [9:0]         texel_row
);

  logic [11:0]        view_angle;
  logic [11:0]        row_shift;
  logic [25:0]        row_step;
  logic [10:0]        tex_height;
  logic [10:0]        tex_width;
  logic [23:0]        height_factor;
  logic signed [11:0] horizon_row;
  logic [10:0]        view_height;

  logic [10:0] h_sat;
  logic [10:0] w_sat;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel & penable & pwrite;
  assign h_sat     = (tex_height > 11'd1024) ? 11'd1024 : tex_height;
  assign w_sat     = (tex_width > 11'd1024) ? 11'd1024 : tex_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_angle    <= '0;
      row_shift     <= '0;
      row_step      <= 26'd65536;
      tex_height    <= 11'd128;
      tex_width     <= 11'd256;
      height_factor <= '0;
      horizon_row   <= '0;
      view_height   <= 11'd200;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_VIEW_ANGLE:    view_angle    <= pwdata[11:0];
        REG_ROW_SHIFT:     row_shift     <= pwdata[11:0];
        REG_ROW_STEP:      row_step      <= pwdata[25:0];
        REG_TEX_HEIGHT:    tex_height    <= pwdata[10:0];
        REG_TEX_WIDTH:     tex_width     <= pwdata[10:0];
        REG_HEIGHT_FACTOR: height_factor <= pwdata[23:0];
        REG_HORIZON_ROW:   horizon_row   <= $signed(pwdata[11:0]);
        REG_VIEW_HEIGHT:   view_height   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_VIEW_ANGLE:    prdata = {20'b0, view_angle};
      REG_ROW_SHIFT:     prdata = {20'b0, row_shift};
      REG_ROW_STEP:      prdata = {6'b0, row_step};
      REG_TEX_HEIGHT:    prdata = {21'b0, tex_height};
      REG_TEX_WIDTH:     prdata = {21'b0, tex_width};
      REG_HEIGHT_FACTOR: prdata = {8'b0, height_factor};
      REG_HORIZON_ROW:   prdata = {20'b0, horizon_row};
      REG_VIEW_HEIGHT:   prdata = {21'b0, view_height};
      default:           prdata = '0;
    endcase
  end

  // three restoring remainder steps
  function automatic rem_t mod_steps(input rem_t rem, input logic [2:0] bits,
                                     input logic [10:0] dvs);
    logic [10:0] r;
    r = {1'b0, rem};
    for (int i = 2; i >= 0; i--) begin
      r = {r[9:0], bits[i]};
      if (r >= dvs) r = r - dvs;
    end
    return r[9:0];
  endfunction

  logic [10:1] vld;

  // stage 1 operands
  logic [15:0]      ang_sum;
  logic [ANG_W-1:0] ang_mod;
  logic [12:0]      row_sum;

  always_comb begin
    ang_sum = {{3{column_angle[12]}}, column_angle} + {4'b0, view_angle}
              + 16'(ANG_BIAS);
    ang_mod = ang_sum[ANG_W-1:0];
    for (int k = 1; k <= ANG_MULTS; k++) begin
      if (ang_sum >= 16'(k * FINE_ANGLES)) ang_mod = ANG_W'(ang_sum - 16'(k * FINE_ANGLES));
    end
    row_sum = {3'b0, screen_row} + {1'b0, row_shift};
  end

  logic [9:0]       row1;
  logic [39:0]      hprod1;
  logic [ANG_W-1:0] ang1;
  logic [38:0]      rprod1;

  always_ff @(posedge clk) begin
    row1   <= screen_row;
    hprod1 <= wall_height * height_factor;
    ang1   <= ang_mod;
    rprod1 <= row_sum * row_step;
  end

  // stage 2: sky test, column product, remainder numerator
  logic signed [25:0] scaled_s;
  logic signed [25:0] hor_s;
  logic signed [25:0] row_s;
  logic               sky_now;
  logic [ANG_W-1:0]   ang_rev;

  always_comb begin
    scaled_s = $signed({2'b0, hprod1[39:FRAC_BITS]});
    hor_s    = {{14{horizon_row[11]}}, horizon_row};
    row_s    = $signed({16'b0, row1});
    sky_now  = ({1'b0, row1} < view_height) &&
               ((row_s < hor_s - scaled_s) || (row_s >= hor_s + scaled_s));
    ang_rev  = ANG_W'(FINE_ANGLES - 1) - ang1;
  end

  logic [10:2]           sky_p;
  logic [COL_PROD_W-1:0] cprod2;
  logic [23:0]           num2;
  logic [44:0]           cq3;
  logic [10:4][9:0]      col_p;

  always_ff @(posedge clk) begin
    sky_p[2] <= sky_now;
    for (int s = 3; s <= 10; s++) sky_p[s] <= sky_p[s-1];
    cprod2   <= COL_PROD_W'(ang_rev * w_sat);
    num2     <= {1'b0, rprod1[38:FRAC_BITS]};
    cq3      <= cprod2 * COL_RECIP;
    col_p[4] <= cq3[COL_SHIFT+9:COL_SHIFT];
    for (int s = 5; s <= 10; s++) col_p[s] <= col_p[s-1];
  end

  // stages 3..10: remainder of the integer row position by the texture height
  rem_t        drem [DIV_STAGES];
  logic [23:0] dnum [DIV_STAGES];

  always_ff @(posedge clk) begin
    drem[0] <= mod_steps('0, num2[23:21], h_sat);
    dnum[0] <= {num2[20:0], 3'b0};
    for (int k = 1; k < DIV_STAGES; k++) begin
      drem[k] <= mod_steps(drem[k-1], dnum[k-1][23:21], h_sat);
      dnum[k] <= {dnum[k-1][20:0], 3'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[9:1], start & ~busy};
    end
  end

  assign done         = vld[10];
  assign draw_sky     = sky_p[10];
  assign texel_column = col_p[10];
  assign texel_row    = (h_sat == 11'd0) ? 10'd0 : drem[DIV_STAGES-1];

  `STAG_ASSERT_NEXT(a_accept_enters, start && !busy && !rst, vld[1])
  `STAG_ASSERT_IMP(a_latency, vld[1], ##9 done)
  `STAG_ASSERT_NEXT(a_reset_quiet, rst, !done)

endmodule
